[sv/assert_macros.svh]
// Assertion macros shared by the dispatch cache RTL.
// Depends on a clock named clock and a reset named reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, skipped while reset is high.
`define MDC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define MDC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/mdc_pkg.sv]
// Package for the method dispatch cache: sizes, codes, entry layout and hash step.
// No dependencies; imported by method_dispatch_cache.
package mdc_pkg;

   localparam int ENTRIES    = 1021;
   localparam int KEY_WIDTH  = 48;
   localparam int DATA_WIDTH = 48;
   localparam int VER_WIDTH  = 32;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = IDX_W + 1;
   // (table_key << 2) wraps at 64 bits
   localparam int HASH_W     = (KEY_WIDTH + 2 > 64) ? 64 : KEY_WIDTH + 2;
   localparam int DIGIT_W    = 8;
   localparam int HASH_STEPS = (HASH_W + DIGIT_W - 1) / DIGIT_W;
   localparam int HASH_PAD   = HASH_STEPS * DIGIT_W;
   localparam int STEP_W     = $clog2(HASH_STEPS + 1);

   localparam logic [IDX_W:0] ENTRIES_EXT = (IDX_W + 1)'(ENTRIES);

   typedef enum logic [1:0] {
      OP_LOOKUP    = 2'd0,
      OP_FILL      = 2'd1,
      OP_FLUSH_ALL = 2'd2,
      OP_FLUSH_SEL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_COMPARE,
      ST_WRITE,
      ST_WIPE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_WIDTH-1:0]  table_tag;
      logic [KEY_WIDTH-1:0]  selector_tag;
      logic [VER_WIDTH-1:0]  version;
      logic [DATA_WIDTH-1:0] method;
      logic [DATA_WIDTH-1:0] defining_table;
   } entry_type;

   // Fold one digit into a running remainder modulo ENTRIES, one bit at a time.
   function automatic logic [IDX_W-1:0] mod_digit(input logic [IDX_W-1:0] rem,
                                                  input logic [DIGIT_W-1:0] digit);
      logic [IDX_W:0] acc;
      acc = {1'b0, rem};
      for (int k = DIGIT_W - 1; k >= 0; k--) begin
         acc = {acc[IDX_W-1:0], digit[k]};
         if (acc >= ENTRIES_EXT) begin
            acc = acc - ENTRIES_EXT;
         end
      end
      return acc[IDX_W-1:0];
   endfunction

endpackage

[sv/method_dispatch_cache.sv]
// Top level of the direct-mapped method dispatch cache: FSM, hash unit and entry memory.
// Depends on mdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Method dispatch cache, direct mapped over ENTRIES slots. Drive an item with start while
// busy is low; exactly one result comes back later as a single-cycle rsp_strobe pulse,
// which cannot be held off, so sample it on that cycle. The slot index is
// ((table_key << 2) xor (selector_key >> 3)) mod ENTRIES, reduced by a shared remainder
// unit that folds 8 hash bits per cycle (HASH_STEPS = 7 digits at 48-bit keys). Entries
// sit in one 1R1W memory with registered read data. A lookup passes the hash, read and
// compare states and a fill the hash and write states; a flush-all clears one slot per
// cycle, and a flush-selector reads one slot per cycle, with the compare and clear of
// each slot overlapping the read of the next. The next item may start in the cycle the
// strobe is shown. After reset the block is busy while it clears all ENTRIES (1021)
// slots. Only lookups report a hit; every other operation and every miss returns zeros.
module method_dispatch_cache
   import mdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [KEY_WIDTH-1:0]  req_table_key,
   input  logic [KEY_WIDTH-1:0]  req_selector_key,
   input  logic [VER_WIDTH-1:0]  req_selector_version,
   input  logic [DATA_WIDTH-1:0] req_fill_method,
   input  logic [DATA_WIDTH-1:0] req_fill_defining_table,
   output logic                  rsp_strobe,
   output logic                  rsp_hit,
   output logic [DATA_WIDTH-1:0] rsp_method_out,
   output logic [DATA_WIDTH-1:0] rsp_defining_table_out
);

   // Control state
   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  sweep_ff, sweep_in;
   logic              chk_ff, chk_in;

   // Captured item and hash datapath
   op_type                op_ff, op_in;
   logic [KEY_WIDTH-1:0]  tkey_ff, tkey_in;
   logic [KEY_WIDTH-1:0]  skey_ff, skey_in;
   logic [VER_WIDTH-1:0]  ver_ff, ver_in;
   logic [DATA_WIDTH-1:0] fmethod_ff, fmethod_in;
   logic [DATA_WIDTH-1:0] fdeftab_ff, fdeftab_in;
   logic [HASH_PAD-1:0]   hash_ff, hash_in;
   logic [IDX_W-1:0]      rem_ff, rem_in;
   logic [IDX_W-1:0]      chk_idx_ff, chk_idx_in;

   // Response registers
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [DATA_WIDTH-1:0] rsp_method_ff, rsp_method_in;
   logic [DATA_WIDTH-1:0] rsp_deftab_ff, rsp_deftab_in;

   // Entry memory
   entry_type        entry_mem [ENTRIES];
   entry_type        mem_q_ff;
   entry_type        mem_wdata;
   logic             mem_we;
   logic             mem_re;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;

   logic              accept;
   logic [HASH_W-1:0] hash_raw;
   logic              hash_last;
   logic              sweep_last;
   logic              scan_more;
   logic              lookup_hit;
   logic              scan_match;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Index hash, wrapped at HASH_W bits, zero-padded on top to whole digits
   assign hash_raw  = (HASH_W'(req_table_key) << 2) ^ HASH_W'(req_selector_key >> 3);
   assign hash_last = (step_ff == STEP_W'(HASH_STEPS - 1));

   assign sweep_last = (sweep_ff == CNT_W'(ENTRIES - 1));
   assign scan_more  = (sweep_ff < CNT_W'(ENTRIES));

   assign lookup_hit = mem_q_ff.valid &&
                       (mem_q_ff.table_tag == tkey_ff) &&
                       (mem_q_ff.selector_tag == skey_ff) &&
                       (mem_q_ff.version == ver_ff);
   assign scan_match = chk_ff && mem_q_ff.valid && (mem_q_ff.selector_tag == skey_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation)) inside
                  OP_LOOKUP, OP_FILL: state_in = ST_HASH;
                  OP_FLUSH_ALL:       state_in = ST_WIPE;
                  OP_FLUSH_SEL:       state_in = ST_SCAN;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_HASH: begin
            if (hash_last) begin
               state_in = (op_ff == OP_LOOKUP) ? ST_READ : ST_WRITE;
            end
         end
         ST_READ:    state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_IDLE;
         ST_WRITE:   state_in = ST_IDLE;
         ST_WIPE: begin
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!scan_more && !chk_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Datapath, memory controls and response
   always_comb begin
      op_in         = op_ff;
      tkey_in       = tkey_ff;
      skey_in       = skey_ff;
      ver_in        = ver_ff;
      fmethod_in    = fmethod_ff;
      fdeftab_in    = fdeftab_ff;
      hash_in       = hash_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      sweep_in      = sweep_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_method_in = '0;
      rsp_deftab_in = '0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = sweep_ff[IDX_W-1:0];
      mem_raddr     = rem_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         ST_INIT: begin
            // Clear one slot per cycle after reset
            mem_we   = 1'b1;
            sweep_in = sweep_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               op_in      = op_type'(req_operation);
               tkey_in    = req_table_key;
               skey_in    = req_selector_key;
               ver_in     = req_selector_version;
               fmethod_in = req_fill_method;
               fdeftab_in = req_fill_defining_table;
               hash_in    = HASH_PAD'(hash_raw);
               rem_in     = '0;
               step_in    = '0;
               sweep_in   = '0;
            end
         end
         ST_HASH: begin
            // Fold the top digit into the remainder, advance to the next
            rem_in  = mod_digit(rem_ff, hash_ff[HASH_PAD-1 -: DIGIT_W]);
            hash_in = hash_ff << DIGIT_W;
            step_in = step_ff + STEP_W'(1);
         end
         ST_READ: begin
            mem_re = 1'b1;
         end
         ST_COMPARE: begin
            rsp_strobe_in = 1'b1;
            if (lookup_hit) begin
               rsp_hit_in    = 1'b1;
               rsp_method_in = mem_q_ff.method;
               rsp_deftab_in = mem_q_ff.defining_table;
            end
         end
         ST_WRITE: begin
            // Overwrite the slot unconditionally
            mem_we                   = 1'b1;
            mem_waddr                = rem_ff;
            mem_wdata.valid          = 1'b1;
            mem_wdata.table_tag      = tkey_ff;
            mem_wdata.selector_tag   = skey_ff;
            mem_wdata.version        = ver_ff;
            mem_wdata.method         = fmethod_ff;
            mem_wdata.defining_table = fdeftab_ff;
            rsp_strobe_in            = 1'b1;
         end
         ST_WIPE: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + CNT_W'(1);
            if (sweep_last) begin
               rsp_strobe_in = 1'b1;
            end
         end
         ST_SCAN: begin
            // Read slot n while checking slot n-1; read and write never share an address
            if (scan_more) begin
               mem_re     = 1'b1;
               mem_raddr  = sweep_ff[IDX_W-1:0];
               sweep_in   = sweep_ff + CNT_W'(1);
               chk_in     = 1'b1;
               chk_idx_in = sweep_ff[IDX_W-1:0];
            end
            if (scan_match) begin
               mem_we    = 1'b1;
               mem_waddr = chk_idx_ff;
            end
            if (!scan_more && !chk_ff) begin
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            sweep_in = '0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         step_ff       <= '0;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         step_ff       <= step_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      tkey_ff       <= tkey_in;
      skey_ff       <= skey_in;
      ver_ff        <= ver_in;
      fmethod_ff    <= fmethod_in;
      fdeftab_ff    <= fdeftab_in;
      hash_ff       <= hash_in;
      rem_ff        <= rem_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_method_ff <= rsp_method_in;
      rsp_deftab_ff <= rsp_deftab_in;
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= entry_mem[mem_raddr];
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_hit                = rsp_hit_ff;
   assign rsp_method_out         = rsp_method_ff;
   assign rsp_defining_table_out = rsp_deftab_ff;

   `MDC_ASSERT(a_accept_sets_busy, accept |=> busy, "accepted item did not raise busy")
   `MDC_ASSERT(a_strobe_after_work, rsp_strobe |-> $past(busy), "response without work")
   `MDC_ASSERT(a_hit_from_lookup, rsp_hit |-> $past(state_ff == ST_COMPARE), "hit off lookup")
   `MDC_ASSERT_ALWAYS(a_no_write_idle, (state_ff == ST_IDLE) |-> !mem_we, "memory write while idle")

endmodule

[tb/tb_method_dispatch_cache.sv]
// Self-checking testbench for the method dispatch cache: directed and random items.
// Depends on mdc_pkg for sizes and operation codes; predicts every reply in a scoreboard class.

// Scoreboard: mirrors the cache slots and queues the reply each accepted item must produce.
class method_cache_scoreboard;
   typedef struct {
      logic                           hit;
      logic [mdc_pkg::DATA_WIDTH-1:0] method;
      logic [mdc_pkg::DATA_WIDTH-1:0] defining_table;
   } dispatch_reply_type;

   bit                             slot_valid     [mdc_pkg::ENTRIES];
   logic [mdc_pkg::KEY_WIDTH-1:0]  slot_table     [mdc_pkg::ENTRIES];
   logic [mdc_pkg::KEY_WIDTH-1:0]  slot_selector  [mdc_pkg::ENTRIES];
   logic [mdc_pkg::VER_WIDTH-1:0]  slot_version   [mdc_pkg::ENTRIES];
   logic [mdc_pkg::DATA_WIDTH-1:0] slot_method    [mdc_pkg::ENTRIES];
   logic [mdc_pkg::DATA_WIDTH-1:0] slot_def_table [mdc_pkg::ENTRIES];

   dispatch_reply_type awaited_replies[$];
   int                 failures;

   function new();
      failures = 0;
      clear_all();
   endfunction

   // Hash in 64-bit arithmetic, shift of the table key wraps at 64 bits.
   static function int unsigned slot_of(logic [mdc_pkg::KEY_WIDTH-1:0] tk,
                                        logic [mdc_pkg::KEY_WIDTH-1:0] sk);
      logic [63:0] h;
      h = (64'(tk) << 2) ^ (64'(sk) >> 3);
      return 32'(h % 64'(mdc_pkg::ENTRIES));
   endfunction

   function void clear_slot(int unsigned i);
      slot_valid[i]     = 1'b0;
      slot_table[i]     = '0;
      slot_selector[i]  = '0;
      slot_version[i]   = '0;
      slot_method[i]    = '0;
      slot_def_table[i] = '0;
   endfunction

   function void clear_all();
      for (int unsigned i = 0; i < mdc_pkg::ENTRIES; i++) clear_slot(i);
   endfunction

   function int pending();
      return awaited_replies.size();
   endfunction

   function void note_item(mdc_pkg::op_type op,
                           logic [mdc_pkg::KEY_WIDTH-1:0] tk,
                           logic [mdc_pkg::KEY_WIDTH-1:0] sk,
                           logic [mdc_pkg::VER_WIDTH-1:0] ver,
                           logic [mdc_pkg::DATA_WIDTH-1:0] meth,
                           logic [mdc_pkg::DATA_WIDTH-1:0] def_table);
      int unsigned        idx;
      dispatch_reply_type r;
      idx              = slot_of(tk, sk);
      r.hit            = 1'b0;
      r.method         = '0;
      r.defining_table = '0;
      case (op)
         mdc_pkg::OP_LOOKUP: begin
            if (slot_valid[idx] && slot_table[idx] == tk && slot_selector[idx] == sk &&
                slot_version[idx] == ver) begin
               r.hit            = 1'b1;
               r.method         = slot_method[idx];
               r.defining_table = slot_def_table[idx];
            end
         end
         mdc_pkg::OP_FILL: begin
            slot_valid[idx]     = 1'b1;
            slot_table[idx]     = tk;
            slot_selector[idx]  = sk;
            slot_version[idx]   = ver;
            slot_method[idx]    = meth;
            slot_def_table[idx] = def_table;
         end
         mdc_pkg::OP_FLUSH_ALL: clear_all();
         mdc_pkg::OP_FLUSH_SEL: begin
            for (int unsigned i = 0; i < mdc_pkg::ENTRIES; i++)
               if (slot_valid[i] && slot_selector[i] == sk) clear_slot(i);
         end
         default: ;
      endcase
      awaited_replies.push_back(r);
   endfunction

   function void check_result(logic hit, logic [mdc_pkg::DATA_WIDTH-1:0] meth,
                              logic [mdc_pkg::DATA_WIDTH-1:0] def_table);
      dispatch_reply_type r;
      if (awaited_replies.size() == 0) begin
         $display("%0t: reply with nothing outstanding: expected none, actual hit %b %h %h",
                  $time, hit, meth, def_table);
         failures++;
         return;
      end
      r = awaited_replies.pop_front();
      if (hit !== r.hit) begin
         $display("%0t: hit mismatch: expected %b, actual %b", $time, r.hit, hit);
         failures++;
      end
      if (meth !== r.method) begin
         $display("%0t: method_out mismatch: expected %h, actual %h", $time, r.method, meth);
         failures++;
      end
      if (def_table !== r.defining_table) begin
         $display("%0t: defining_table_out mismatch: expected %h, actual %h",
                  $time, r.defining_table, def_table);
         failures++;
      end
   endfunction
endclass

module tb_method_dispatch_cache;
   timeunit 1ns;
   timeprecision 1ps;
   import mdc_pkg::*;

   localparam int RANDOM_ITEMS = 680;
   localparam int QUIET_TAIL   = 100;   // last items get no random idle gaps
   localparam int POOL_DEPTH   = 24;
   // Worst case is every item a flush-selector plus the longest idle gap, after the
   // clearing pass; the limit allows several times that.
   localparam int CYCLE_LIMIT  = 4_000_000;

   typedef struct {
      logic [KEY_WIDTH-1:0] tk;
      logic [KEY_WIDTH-1:0] sk;
      logic [VER_WIDTH-1:0] ver;
   } filled_key_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_operation           = '0;
   logic [KEY_WIDTH-1:0]  req_table_key           = '0;
   logic [KEY_WIDTH-1:0]  req_selector_key        = '0;
   logic [VER_WIDTH-1:0]  req_selector_version    = '0;
   logic [DATA_WIDTH-1:0] req_fill_method         = '0;
   logic [DATA_WIDTH-1:0] req_fill_defining_table = '0;
   logic                  rsp_strobe;
   logic                  rsp_hit;
   logic [DATA_WIDTH-1:0] rsp_method_out;
   logic [DATA_WIDTH-1:0] rsp_defining_table_out;

   int                     cycle_count = 0;
   method_cache_scoreboard sb = new();
   filled_key_type         recent_fills[$];

   method_dispatch_cache dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_operation           (req_operation),
      .req_table_key           (req_table_key),
      .req_selector_key        (req_selector_key),
      .req_selector_version    (req_selector_version),
      .req_fill_method         (req_fill_method),
      .req_fill_defining_table (req_fill_defining_table),
      .rsp_strobe              (rsp_strobe),
      .rsp_hit                 (rsp_hit),
      .rsp_method_out          (rsp_method_out),
      .rsp_defining_table_out  (rsp_defining_table_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run: a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Replies cannot be held off: take each one on its strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         sb.check_result(rsp_hit, rsp_method_out, rsp_defining_table_out);
      end
   end

   function automatic logic [DATA_WIDTH-1:0] rand_data();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[DATA_WIDTH-1:0];
   endfunction

   // Mix wide keys with clustered small and near-all-ones keys so that slots alias
   // and selectors repeat across tables.
   function automatic logic [KEY_WIDTH-1:0] pick_key();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: return KEY_WIDTH'($urandom_range(0, 15)) << 3;
         1: return ~KEY_WIDTH'($urandom_range(0, 15));
         default: return w[KEY_WIDTH-1:0];
      endcase
   endfunction

   // Present an item and hold it until accepted; leave start high so the next item can
   // follow without a gap.
   task automatic drive_item(op_type op, logic [KEY_WIDTH-1:0] tk, logic [KEY_WIDTH-1:0] sk,
                             logic [VER_WIDTH-1:0] ver, logic [DATA_WIDTH-1:0] meth,
                             logic [DATA_WIDTH-1:0] def_table);
      start                   <= 1'b1;
      req_operation           <= op;
      req_table_key           <= tk;
      req_selector_key        <= sk;
      req_selector_version    <= ver;
      req_fill_method         <= meth;
      req_fill_defining_table <= def_table;
      do @(posedge clock); while (busy);
      sb.note_item(op, tk, sk, ver, meth, def_table);
   endtask

   task automatic idle_cycles(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding reply is back.
   task automatic drain_replies();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic fill_item(logic [KEY_WIDTH-1:0] tk, logic [KEY_WIDTH-1:0] sk,
                            logic [VER_WIDTH-1:0] ver);
      drive_item(OP_FILL, tk, sk, ver, rand_data(), rand_data());
      recent_fills.push_back('{tk, sk, ver});
      if (recent_fills.size() > POOL_DEPTH) void'(recent_fills.pop_front());
   endtask

   initial begin
      logic [KEY_WIDTH-1:0] ta, sa, t_alias, sd;
      logic [KEY_WIDTH-1:0] tk, sk;
      logic [VER_WIDTH-1:0] ver;
      filled_key_type       f;
      int                   r;

      ta = 48'h0000_1234_5678;
      sa = 48'h0000_00AB_CD00;
      sd = 48'h0000_0077_0000;
      // Find a second table key landing in the same slot as (ta, sa).
      t_alias = 1;
      while (sb.slot_of(t_alias, sa) != sb.slot_of(ta, sa))
         t_alias++;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: a cleared slot holds all-zero tags yet must miss.
      drive_item(OP_LOOKUP, '0, '0, '0, '0, '0);
      // Extremes: all-ones keys, version and data, then hit and near misses.
      drive_item(OP_FILL, '1, '1, '1, '1, '1);
      drive_item(OP_LOOKUP, '1, '1, '1, '0, '0);
      drive_item(OP_LOOKUP, '1, '1, 32'hFFFF_FFFE, '1, '1);
      drive_item(OP_LOOKUP, 48'h7FFF_FFFF_FFFF, '1, '1, '0, '0);
      drive_item(OP_LOOKUP, '1, 48'hFFFF_FFFF_FFF7, '1, '0, '0);
      // All-zero entry made valid by a fill returns a hit with zero data.
      drive_item(OP_FILL, '0, '0, '0, '0, '0);
      drive_item(OP_LOOKUP, '0, '0, '0, '1, '1);
      // Overwrite an occupied slot with an aliasing key pair.
      drive_item(OP_FILL, ta, sa, 32'd5, rand_data(), rand_data());
      drive_item(OP_LOOKUP, ta, sa, 32'd5, '0, '0);
      drive_item(OP_FILL, t_alias, sa, 32'd6, rand_data(), rand_data());
      drive_item(OP_LOOKUP, ta, sa, 32'd5, '0, '0);
      drive_item(OP_LOOKUP, t_alias, sa, 32'd6, '0, '0);
      // Flush one selector: entries of sa go, the one under sd stays.
      drive_item(OP_FILL, ta ^ 48'h0000_0000_0100, sa, 32'd7, rand_data(), rand_data());
      drive_item(OP_FILL, ta, sd, 32'd8, rand_data(), rand_data());
      drive_item(OP_FLUSH_SEL, rand_data(), sa, $urandom, rand_data(), rand_data());
      drive_item(OP_LOOKUP, t_alias, sa, 32'd6, '0, '0);
      drive_item(OP_LOOKUP, ta ^ 48'h0000_0000_0100, sa, 32'd7, '0, '0);
      drive_item(OP_LOOKUP, ta, sd, 32'd8, '0, '0);
      drive_item(OP_LOOKUP, '1, '1, '1, '0, '0);
      // Flush everything, then nothing may hit.
      drive_item(OP_FLUSH_ALL, '1, '1, '1, '1, '1);
      drive_item(OP_LOOKUP, '1, '1, '1, '0, '0);
      drive_item(OP_LOOKUP, ta, sd, 32'd8, '0, '0);
      drain_replies();

      // Random: lookups mostly replay recent fills so hits and tag misses both occur.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         r   = $urandom_range(0, 99);
         tk  = pick_key();
         sk  = pick_key();
         ver = $urandom;
         if (r < 45) begin
            if (recent_fills.size() != 0 && $urandom_range(0, 9) < 7) begin
               f   = recent_fills[$urandom_range(0, recent_fills.size() - 1)];
               tk  = f.tk;
               sk  = f.sk;
               ver = f.ver;
               case ($urandom_range(0, 7))
                  0: ver = ver ^ (VER_WIDTH'(1) << $urandom_range(0, VER_WIDTH - 1));
                  1: tk  = tk ^ (KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1));
                  2: sk  = sk ^ (KEY_WIDTH'(1) << $urandom_range(0, KEY_WIDTH - 1));
                  default: ;
               endcase
            end
            drive_item(OP_LOOKUP, tk, sk, ver, rand_data(), rand_data());
         end else if (r < 88) begin
            fill_item(tk, sk, ver);
         end else if (r < 91) begin
            drive_item(OP_FLUSH_ALL, tk, sk, ver, rand_data(), rand_data());
         end else begin
            if (recent_fills.size() != 0 && $urandom_range(0, 9) < 7)
               sk = recent_fills[$urandom_range(0, recent_fills.size() - 1)].sk;
            drive_item(OP_FLUSH_SEL, tk, sk, ver, rand_data(), rand_data());
         end

         if (k % 200 == 199) begin
            drain_replies();
         end else if (k < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            idle_cycles($urandom_range(1, 3));
         end
      end

      // Drop start, wait out every reply, then allow a flush's worth of extra cycles.
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/mdc_pkg.sv
sv/method_dispatch_cache.sv
tb/tb_method_dispatch_cache.sv
